// File: hw/rtl/pwbc_pkg.sv
// Shared types and constants for the pulse width bin classifier.
// Item structs, operation and class codes, register indexes, reset values.
// No dependencies.
`default_nettype none

package pwbc_pkg;

  // Storage width of the width counter and the class counters
  localparam int unsigned CountWidthDef = 16;

  localparam int unsigned BoundWidth = 16;
  localparam int unsigned FieldWidth = 16;
  localparam int unsigned CfgIdxWidth = 3;

  // Operation codes of an input item
  localparam logic [1:0] OP_TICK  = 2'd0;
  localparam logic [1:0] OP_EDGE  = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  // Class codes of a finished pulse
  localparam logic [1:0] CLASS_BAND1  = 2'd0;
  localparam logic [1:0] CLASS_BAND2  = 2'd1;
  localparam logic [1:0] CLASS_BAND3  = 2'd2;
  localparam logic [1:0] CLASS_DEFECT = 2'd3;

  // Configuration register indexes
  localparam logic [CfgIdxWidth-1:0] REG_BAND1_LOW  = 3'd0;
  localparam logic [CfgIdxWidth-1:0] REG_BAND1_HIGH = 3'd1;
  localparam logic [CfgIdxWidth-1:0] REG_BAND2_LOW  = 3'd2;
  localparam logic [CfgIdxWidth-1:0] REG_BAND2_HIGH = 3'd3;
  localparam logic [CfgIdxWidth-1:0] REG_BAND3_LOW  = 3'd4;
  localparam logic [CfgIdxWidth-1:0] REG_BAND3_HIGH = 3'd5;

  // Band bound reset values
  localparam logic [BoundWidth-1:0] BAND1_LOW_RST  = 16'd12;
  localparam logic [BoundWidth-1:0] BAND1_HIGH_RST = 16'd20;
  localparam logic [BoundWidth-1:0] BAND2_LOW_RST  = 16'd34;
  localparam logic [BoundWidth-1:0] BAND2_HIGH_RST = 16'd40;
  localparam logic [BoundWidth-1:0] BAND3_LOW_RST  = 16'd46;
  localparam logic [BoundWidth-1:0] BAND3_HIGH_RST = 16'd56;

  typedef struct packed {
    logic [1:0] operation;
    logic       sensor_level;
    logic       system_enabled;
  } in_t;

  typedef struct packed {
    logic                  measuring;
    logic                  alarm;
    logic                  classified;
    logic [1:0]            class_code;
    logic [FieldWidth-1:0] pulse_ticks;
    logic [FieldWidth-1:0] count_band1;
    logic [FieldWidth-1:0] count_band2;
    logic [FieldWidth-1:0] count_band3;
    logic [FieldWidth-1:0] count_defective;
  } out_t;

  // Inclusive bounds of the three width bands
  typedef struct packed {
    logic [BoundWidth-1:0] band1_low;
    logic [BoundWidth-1:0] band1_high;
    logic [BoundWidth-1:0] band2_low;
    logic [BoundWidth-1:0] band2_high;
    logic [BoundWidth-1:0] band3_low;
    logic [BoundWidth-1:0] band3_high;
  } bands_t;

endpackage

`default_nettype wire

// File: hw/rtl/pwbc_classify.sv
// Band match of a measured pulse width against the three inclusive bands.
// Depends on pwbc_pkg (bands_t, class codes).
`default_nettype none

module pwbc_classify #(
  parameter int unsigned COUNT_WIDTH = pwbc_pkg::CountWidthDef
) (
  input  wire logic [COUNT_WIDTH-1:0] width_i,
  input  wire pwbc_pkg::bands_t       bands_i,
  output logic [1:0]                  class_code_o
);

  // Compare at the wider of counter and bound widths
  localparam int unsigned CmpW = (COUNT_WIDTH > pwbc_pkg::BoundWidth) ?
                                 COUNT_WIDTH : pwbc_pkg::BoundWidth;

  logic [CmpW-1:0] width_ext;
  logic            hit1, hit2, hit3;

  assign width_ext = CmpW'(width_i);

  assign hit1 = (CmpW'(bands_i.band1_low) <= width_ext) &&
                (width_ext <= CmpW'(bands_i.band1_high));
  assign hit2 = (CmpW'(bands_i.band2_low) <= width_ext) &&
                (width_ext <= CmpW'(bands_i.band2_high));
  assign hit3 = (CmpW'(bands_i.band3_low) <= width_ext) &&
                (width_ext <= CmpW'(bands_i.band3_high));

  // First matching band in order wins
  always_comb begin
    if (hit1) begin
      class_code_o = pwbc_pkg::CLASS_BAND1;
    end else if (hit2) begin
      class_code_o = pwbc_pkg::CLASS_BAND2;
    end else if (hit3) begin
      class_code_o = pwbc_pkg::CLASS_BAND3;
    end else begin
      class_code_o = pwbc_pkg::CLASS_DEFECT;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/pulse_width_bin_classifier.sv
// Top level of the pulse width bin classifier.
// Depends on pwbc_pkg and pwbc_classify.
//
// Usage: every input item (timer tick, sensor edge or clear) yields exactly
// one result item carrying the measurement flag, the alarm, the class of a
// pulse finished by this item and the width and class counters after the
// update. Band bounds are written through the cfg_we_i / cfg_idx_i /
// cfg_data_i port while the block is idle; indexes beyond the last band
// register are dropped.
// The result is registered and appears on out_data_o in the cycle after the
// item is accepted. Throughput: one item per cycle while the output is not
// stalled, set by the single update of the pulse state and counters between
// the input handshake and the result register.
// Stall: while a result waits, in_ready_o follows out_ready_i, so an item
// is taken in the same cycle the waiting result leaves; with the output
// stalled, no item enters and the result holds.
// Reset: bounds return to their defaults (12..20, 34..40, 46..56), all
// counters, the measurement flag and the alarm clear, and no result is
// pending.
`default_nettype none

module pulse_width_bin_classifier #(
  parameter int unsigned COUNT_WIDTH = pwbc_pkg::CountWidthDef
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             in_valid_i,
  output logic                                  in_ready_o,
  input  wire pwbc_pkg::in_t                    in_data_i,
  output logic                                  out_valid_o,
  input  wire logic                             out_ready_i,
  output pwbc_pkg::out_t                        out_data_o,
  input  wire logic                             cfg_we_i,
  input  wire logic [pwbc_pkg::CfgIdxWidth-1:0] cfg_idx_i,
  input  wire logic [pwbc_pkg::BoundWidth-1:0]  cfg_data_i
);

  localparam logic [COUNT_WIDTH-1:0] CntMax = {COUNT_WIDTH{1'b1}};

  pwbc_pkg::bands_t       bands_q;
  logic                   in_pulse_q, in_pulse_d;
  logic                   alarm_q, alarm_d;
  logic [COUNT_WIDTH-1:0] ticks_q, ticks_d;
  logic [COUNT_WIDTH-1:0] cnt_q [4];
  logic [COUNT_WIDTH-1:0] cnt_d [4];
  logic                   done;
  logic [1:0]             match_code;
  logic [1:0]             code;
  logic                   accept;
  logic                   out_valid_q;
  pwbc_pkg::out_t         out_q, out_d;

  // Band registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bands_q.band1_low  <= pwbc_pkg::BAND1_LOW_RST;
      bands_q.band1_high <= pwbc_pkg::BAND1_HIGH_RST;
      bands_q.band2_low  <= pwbc_pkg::BAND2_LOW_RST;
      bands_q.band2_high <= pwbc_pkg::BAND2_HIGH_RST;
      bands_q.band3_low  <= pwbc_pkg::BAND3_LOW_RST;
      bands_q.band3_high <= pwbc_pkg::BAND3_HIGH_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        pwbc_pkg::REG_BAND1_LOW:  bands_q.band1_low  <= cfg_data_i;
        pwbc_pkg::REG_BAND1_HIGH: bands_q.band1_high <= cfg_data_i;
        pwbc_pkg::REG_BAND2_LOW:  bands_q.band2_low  <= cfg_data_i;
        pwbc_pkg::REG_BAND2_HIGH: bands_q.band2_high <= cfg_data_i;
        pwbc_pkg::REG_BAND3_LOW:  bands_q.band3_low  <= cfg_data_i;
        pwbc_pkg::REG_BAND3_HIGH: bands_q.band3_high <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Width of the pulse being closed is the current counter value
  pwbc_classify #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_classify (
    .width_i      (ticks_q),
    .bands_i      (bands_q),
    .class_code_o (match_code)
  );

  // Output register frees the input side as soon as the result leaves
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  // Next pulse state and counters for the item on the input
  always_comb begin
    in_pulse_d = in_pulse_q;
    alarm_d    = alarm_q;
    ticks_d    = ticks_q;
    done       = 1'b0;
    code       = pwbc_pkg::CLASS_BAND1;
    for (int i = 0; i < 4; i++) begin
      cnt_d[i] = cnt_q[i];
    end
    unique case (in_data_i.operation)
      pwbc_pkg::OP_TICK: begin
        ticks_d = (ticks_q == CntMax) ? CntMax : ticks_q + 1'b1;
      end
      pwbc_pkg::OP_EDGE: begin
        if (in_data_i.system_enabled) begin
          if (!in_pulse_q && !in_data_i.sensor_level) begin
            // falling edge opens a measurement
            in_pulse_d = 1'b1;
            ticks_d    = '0;
          end else if (in_pulse_q && in_data_i.sensor_level) begin
            // rising edge closes it and books the class
            in_pulse_d = 1'b0;
            done       = 1'b1;
            code       = match_code;
            alarm_d    = (match_code == pwbc_pkg::CLASS_DEFECT);
            ticks_d    = '0;
            cnt_d[match_code] = (cnt_q[match_code] == CntMax) ?
                                CntMax : cnt_q[match_code] + 1'b1;
          end
        end
      end
      pwbc_pkg::OP_CLEAR: begin
        for (int i = 0; i < 4; i++) begin
          cnt_d[i] = '0;
        end
      end
      default: ;
    endcase
  end

  // Result fields taken after the update
  always_comb begin
    out_d.measuring       = in_pulse_d;
    out_d.alarm           = alarm_d;
    out_d.classified      = done;
    out_d.class_code      = code;
    out_d.pulse_ticks     = pwbc_pkg::FieldWidth'(ticks_d);
    out_d.count_band1     = pwbc_pkg::FieldWidth'(cnt_d[pwbc_pkg::CLASS_BAND1]);
    out_d.count_band2     = pwbc_pkg::FieldWidth'(cnt_d[pwbc_pkg::CLASS_BAND2]);
    out_d.count_band3     = pwbc_pkg::FieldWidth'(cnt_d[pwbc_pkg::CLASS_BAND3]);
    out_d.count_defective = pwbc_pkg::FieldWidth'(cnt_d[pwbc_pkg::CLASS_DEFECT]);
  end

  // Pulse state and counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_pulse_q <= 1'b0;
      alarm_q    <= 1'b0;
      ticks_q    <= '0;
      for (int i = 0; i < 4; i++) begin
        cnt_q[i] <= '0;
      end
    end else if (accept) begin
      in_pulse_q <= in_pulse_d;
      alarm_q    <= alarm_d;
      ticks_q    <= ticks_d;
      for (int i = 0; i < 4; i++) begin
        cnt_q[i] <= cnt_d[i];
      end
    end
  end

  // Result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

// File: hw/rtl/pwbc_checker.sv
// Port-level checks of the pulse width bin classifier, bound to its top level.
// Depends on pwbc_pkg.
`default_nettype none

module pwbc_checker (
  input wire logic           clk_i,
  input wire logic           rst_ni,
  input wire logic           in_valid_i,
  input wire logic           in_ready_o,
  input wire logic           out_valid_o,
  input wire logic           out_ready_i,
  input wire pwbc_pkg::out_t out_data_o
);

  // A stalled result stays valid
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // An item accepted always produces a result next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> out_valid_o)
    else $error("accepted item gave no result");

  // Unclassified results report band 1 as class code
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.classified |->
      out_data_o.class_code == pwbc_pkg::CLASS_BAND1)
    else $error("class code set without a finished pulse");

  // A finished pulse ends timing, zeroes width, and alarm tracks defect
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.classified |->
      !out_data_o.measuring && out_data_o.pulse_ticks == '0 &&
      out_data_o.alarm == (out_data_o.class_code == pwbc_pkg::CLASS_DEFECT))
    else $error("inconsistent finished pulse result");

endmodule

bind pulse_width_bin_classifier pwbc_checker u_pwbc_checker (.*);

`default_nettype wire
